// ===== hdl/vbrb_pkg.sv =====
// vbrb_pkg: types and constants shared by the variable block ring buffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vbrb_pkg;

  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int AVAIL_W    = 11;
  localparam int MIN_BLOCK  = 6;
  localparam int LEN_OFFSET = 4;
  localparam int HIGH_SHIFT = 8;

  localparam logic [AVAIL_W-1:0] AVAIL_MAX = 11'd2047;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 4;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic               not_connected;
    logic [AVAIL_W-1:0] available;
    logic               end_of_read;
    logic               end_of_block;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_valid;
    logic               accepted;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/vbrb_ram.sv =====
// vbrb_ram: simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module vbrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/variable_block_ring_buffer.sv =====
// variable_block_ring_buffer: byte ring holding whole variable-length blocks
// depends on vbrb_pkg and vbrb_ram
//
//   channel  dir  handshake               payload
//   in_      in   in_tvalid / in_tready   tdata: data_byte, blk_len, read_budget
//                                         tuser: cmd, first_byte
//   out_     out  out_tvalid / out_tready tdata: out_byte, available
//                                         tuser: flags, tlast: end_of_block
//   cfg_     in   cfg_we                  cfg_wdata: enable
//
// push, begin read, refused and unused commands: answered from the idle state
// fetch inside a block: one ram read, registered data
// fetch at a block start with six or more bytes held first peeks at the header length;
// the last byte of a block also peeks at the next header if six or more bytes remain
// one beat in flight; in_tready waits for the output register to drain
// reset clears pointers and counters; ring contents stay undefined, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module variable_block_ring_buffer #(
  parameter int RING_BYTES = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // data_byte[7:0], blk_len[23:8], read_budget[39:24]
  input  wire logic [vbrb_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd[1:0], first_byte[2]
  input  wire logic [vbrb_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_byte[7:0], available[18:8], zero[23:19]
  output logic      [vbrb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // accepted[0], out_valid[1], end_of_read[2], not_connected[3]
  output logic      [vbrb_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_wdata
);

  import vbrb_pkg::*;

  localparam int AW = $clog2(RING_BYTES);
  localparam int FW = $clog2(RING_BYTES + 1);
  localparam int CW = (FW > LEN_W) ? FW : LEN_W;

  localparam logic [AW:0]   RING_A = (AW+1)'(RING_BYTES);
  localparam logic [FW-1:0] RING_F = FW'(RING_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PEEK_LO,
    ST_PEEK_HI,
    ST_BYTE
  } state_t;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
    logic [AW:0] s;
    s = (a >= RING_A) ? (a - RING_A) : a;
    return s[AW-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] x,
                                                 input logic [FW-1:0] used);
    logic [CW-1:0] v;
    v = CW'(x);
    if (v < CW'(MIN_BLOCK)) v = CW'(MIN_BLOCK);
    if (v > CW'(used)) v = CW'(used);
    return v[LEN_W-1:0];
  endfunction

  state_t            st_r, st_nxt;
  logic              en_r, en_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [FW-1:0]     free_r, free_nxt;
  logic              keep_r, keep_nxt;
  logic [LEN_W-1:0]  pleft_r, pleft_nxt;
  logic [LEN_W-1:0]  cur_r, cur_nxt;
  logic [LEN_W-1:0]  budget_r, budget_nxt;
  logic [LEN_W-1:0]  bleft_r, bleft_nxt;
  logic              after_r, after_nxt;
  logic [BYTE_W-1:0] lo_r, lo_nxt;
  res_t              res_r, res_nxt;
  logic              ovld_r, ovld_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  cmd_t              in_cmd;
  logic [BYTE_W-1:0] in_data_byte;
  logic              in_first_byte;
  logic [LEN_W-1:0]  in_blk_len;
  logic [LEN_W-1:0]  in_read_budget;
  logic              accept;
  logic [FW-1:0]     held;
  logic [CW-1:0]     held_c;

  assign in_cmd         = cmd_t'(in_tuser[1:0]);
  assign in_first_byte  = in_tuser[2];
  assign in_data_byte   = in_tdata[7:0];
  assign in_blk_len     = in_tdata[23:8];
  assign in_read_budget = in_tdata[39:24];

  assign in_tready = (st_r == ST_IDLE) && (!ovld_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign held      = RING_F - free_r;
  assign held_c    = CW'(held);

  vbrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic             p_keep;
    logic [LEN_W-1:0] p_left;
    logic [LEN_W-1:0] p_cur;
    logic [LEN_W-1:0] p_off;
    logic [LEN_W-1:0] hlen;
    logic [LEN_W-1:0] slen;
    logic [AW-1:0]    rp_inc;
    logic [FW-1:0]    held_dec;

    st_nxt     = st_r;
    en_nxt     = en_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    free_nxt   = free_r;
    keep_nxt   = keep_r;
    pleft_nxt  = pleft_r;
    cur_nxt    = cur_r;
    budget_nxt = budget_r;
    bleft_nxt  = bleft_r;
    after_nxt  = after_r;
    lo_nxt     = lo_r;
    res_nxt    = res_r;
    ovld_nxt   = ovld_r;
    ram_we     = 1'b0;
    ram_waddr  = wp_r;
    ram_wdata  = in_data_byte;
    ram_raddr  = rp_r;

    p_keep   = keep_r;
    p_left   = pleft_r;
    p_cur    = cur_r;
    p_off    = '0;
    hlen     = clamp_len((LEN_W'(ram_rdata) << HIGH_SHIFT) | LEN_W'(lo_r), held);
    slen     = LEN_W'(held);
    rp_inc   = wrap({1'b0, rp_r} + (AW+1)'(1));
    held_dec = held - FW'(1);

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (in_cmd == CMD_NONE) begin
            ovld_nxt = 1'b1;
          end else if (!en_r) begin
            res_nxt.not_connected = 1'b1;
            ovld_nxt              = 1'b1;
          end else begin
            unique case (in_cmd)
              CMD_PUSH: begin
                ovld_nxt = 1'b1;
                if (in_first_byte) begin
                  p_keep = 1'b0;
                  p_left = '0;
                  p_cur  = '0;
                  if (CW'(in_blk_len) >= CW'(MIN_BLOCK) &&
                      CW'(in_blk_len) <= CW'(free_r)) begin
                    p_keep = 1'b1;
                    p_left = in_blk_len;
                    p_cur  = in_blk_len;
                  end
                end
                keep_nxt  = p_keep;
                pleft_nxt = p_left;
                cur_nxt   = p_cur;
                if (p_keep && p_left != '0) begin
                  p_off     = p_cur - p_left;
                  ram_we    = 1'b1;
                  ram_waddr = wrap({1'b0, wp_r} + (AW+1)'(p_off));
                  pleft_nxt = p_left - LEN_W'(1);
                  res_nxt.accepted = 1'b1;
                  if (p_left == LEN_W'(1)) begin
                    wp_nxt   = wrap({1'b0, wp_r} + (AW+1)'(p_cur));
                    free_nxt = free_r - FW'(p_cur);
                    keep_nxt = 1'b0;
                  end
                end
              end
              CMD_BEGIN: begin
                ovld_nxt   = 1'b1;
                budget_nxt = in_read_budget;
                res_nxt.available = (held_c > CW'(AVAIL_MAX)) ? AVAIL_MAX
                                                                : held_c[AVAIL_W-1:0];
              end
              CMD_FETCH: begin
                if (bleft_r != '0) begin
                  ram_raddr = rp_r;
                  st_nxt    = ST_BYTE;
                end else if (held == '0) begin
                  res_nxt.end_of_read = 1'b1;
                  ovld_nxt            = 1'b1;
                end else if (held_c < CW'(MIN_BLOCK)) begin
                  if (slen > budget_r) begin
                    res_nxt.end_of_read = 1'b1;
                    ovld_nxt            = 1'b1;
                  end else begin
                    budget_nxt = budget_r - slen;
                    bleft_nxt  = slen;
                    ram_raddr  = rp_r;
                    st_nxt     = ST_BYTE;
                  end
                end else begin
                  ram_raddr = wrap({1'b0, rp_r} + (AW+1)'(LEN_OFFSET));
                  after_nxt = 1'b0;
                  st_nxt    = ST_PEEK_LO;
                end
              end
              default: begin
                ovld_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      ST_PEEK_LO: begin
        lo_nxt    = ram_rdata;
        ram_raddr = wrap({1'b0, rp_r} + (AW+1)'(LEN_OFFSET + 1));
        st_nxt    = ST_PEEK_HI;
      end
      ST_PEEK_HI: begin
        if (after_r || hlen > budget_r) begin
          res_nxt.end_of_read = (hlen > budget_r);
          ovld_nxt            = 1'b1;
          st_nxt              = ST_IDLE;
        end else begin
          budget_nxt = budget_r - hlen;
          bleft_nxt  = hlen;
          ram_raddr  = rp_r;
          st_nxt     = ST_BYTE;
        end
      end
      ST_BYTE: begin
        res_nxt.out_valid = 1'b1;
        res_nxt.out_byte  = ram_rdata;
        rp_nxt            = rp_inc;
        free_nxt          = free_r + FW'(1);
        bleft_nxt         = bleft_r - LEN_W'(1);
        st_nxt            = ST_IDLE;
        ovld_nxt          = 1'b1;
        if (bleft_r == LEN_W'(1)) begin
          res_nxt.end_of_block = 1'b1;
          if (held_dec == '0) begin
            res_nxt.end_of_read = 1'b1;
          end else if (CW'(held_dec) < CW'(MIN_BLOCK)) begin
            res_nxt.end_of_read = (LEN_W'(held_dec) > budget_r);
          end else begin
            ovld_nxt  = 1'b0;
            ram_raddr = wrap({1'b0, rp_inc} + (AW+1)'(LEN_OFFSET));
            after_nxt = 1'b1;
            st_nxt    = ST_PEEK_LO;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      en_nxt     = cfg_wdata;
      wp_nxt     = '0;
      rp_nxt     = '0;
      free_nxt   = RING_F;
      keep_nxt   = 1'b0;
      pleft_nxt  = '0;
      cur_nxt    = '0;
      budget_nxt = '0;
      bleft_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      en_r     <= 1'b0;
      wp_r     <= '0;
      rp_r     <= '0;
      free_r   <= RING_F;
      keep_r   <= 1'b0;
      pleft_r  <= '0;
      cur_r    <= '0;
      budget_r <= '0;
      bleft_r  <= '0;
      after_r  <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      en_r     <= en_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      free_r   <= free_nxt;
      keep_r   <= keep_nxt;
      pleft_r  <= pleft_nxt;
      cur_r    <= cur_nxt;
      budget_r <= budget_nxt;
      bleft_r  <= bleft_nxt;
      after_r  <= after_nxt;
      ovld_r   <= ovld_nxt;
    end
    lo_r  <= lo_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {(OUT_TDATA_W - AVAIL_W - BYTE_W)'(0), res_r.available, res_r.out_byte};
  assign out_tuser  = {res_r.not_connected, res_r.end_of_read, res_r.out_valid,
                       res_r.accepted};
  assign out_tlast  = res_r.end_of_block;

  // output register stays empty while a fetch is being worked on
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !ovld_r)
    else $error("result pending during fetch sequence");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(free_r) <= CW'(RING_BYTES))
    else $error("free count above ring size");

  a_byte_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BYTE) |-> (bleft_r != '0))
    else $error("byte read outside a block");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (st_r == ST_IDLE && accept))
    else $error("ring write outside an accepted push");

  a_peek_hi_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PEEK_LO) |=> (st_r == ST_PEEK_HI))
    else $error("header peek sequence broken");

endmodule

`default_nettype wire
